FILE: hdl/mp2d_pkg.sv
// Shared types and constants of the int8 2-D max pooling block.
// Used by the controller, the datapath and the top level; no dependencies.
package mp2d_pkg;

  localparam int unsigned MaxWidthDef       = 256;
  localparam int unsigned MaxHeightDef      = 256;
  localparam int unsigned MaxKernelRowsDef  = 8;
  localparam int unsigned MaxKernelColsDef  = 8;

  localparam int unsigned PixW   = 8;
  localparam int unsigned DimW   = 9;   // plane size registers
  localparam int unsigned KerW   = 4;   // kernel and stride registers
  localparam int unsigned OffW   = 9;   // offset registers
  localparam int unsigned CfgW   = 9;   // widest register
  localparam int unsigned IdxW   = 3;
  localparam int unsigned OutW   = 24;  // pooled, out_row, out_col
  localparam int unsigned AccW   = 10;  // pixel plus offset

  localparam logic signed [AccW-1:0] PoolFloor = -10'sd128;

  typedef enum logic [IdxW-1:0] {
    CFG_PLANE_HEIGHT = 3'd0,
    CFG_PLANE_WIDTH  = 3'd1,
    CFG_KERNEL_ROWS  = 3'd2,
    CFG_KERNEL_COLS  = 3'd3,
    CFG_STRIDE_ROWS  = 3'd4,
    CFG_STRIDE_COLS  = 3'd5,
    CFG_IN_OFFSET    = 3'd6,
    CFG_OUT_OFFSET   = 3'd7
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic accept;    // take the input transfer, start the dividers
    logic div_step;  // one restoring division step on every lane
    logic write_px;  // store the pixel, prime the window walk
    logic walk;      // issue one line store read of the window
    logic load;      // move the maximum into the output register
    logic advance;   // step to the next plane position
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic hit;
    logic walk_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hdl/mp2d_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module mp2d_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mp2d_ctrl.sv
// Sequencing state machine of the max pooling block.
// Depends on mp2d_pkg for the command and status structs.
module mp2d_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mp2d_pkg::dp_status_t status_i,
  output mp2d_pkg::ctrl_cmd_t  cmd_o
);
  import mp2d_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_WRITE = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_LOAD  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write_px = 1'b1;
        if (status_i.hit) begin
          state_d = ST_WALK;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_last) state_d = ST_DRAIN;
      end
      // last read still folding into the maximum
      ST_DRAIN: state_d = ST_LOAD;
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.advance = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/mp2d_datapath.sv
// Datapath of the max pooling block: registers, position counters,
// restoring dividers, line store and window maximum. Depends on mp2d_pkg, mp2d_ram.
module mp2d_datapath #(
  parameter int unsigned MaxWidth      = mp2d_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight     = mp2d_pkg::MaxHeightDef,
  parameter int unsigned MaxKernelRows = mp2d_pkg::MaxKernelRowsDef,
  parameter int unsigned MaxKernelCols = mp2d_pkg::MaxKernelColsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mp2d_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [mp2d_pkg::CfgW-1:0]  cfg_data_i,
  input  logic [mp2d_pkg::PixW-1:0]  pixel_i,
  input  logic                       last_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [mp2d_pkg::OutW-1:0]  out_data_o,
  input  mp2d_pkg::ctrl_cmd_t        cmd_i,
  output mp2d_pkg::dp_status_t       status_o
);
  import mp2d_pkg::*;

  localparam int unsigned RW    = $clog2(MaxHeight);
  localparam int unsigned CW    = $clog2(MaxWidth);
  localparam int unsigned RXW   = (RW + 1 > 10) ? RW + 1 : 10;
  localparam int unsigned CXW   = (CW + 1 > 10) ? CW + 1 : 10;
  localparam int unsigned DivW  = (RXW > CXW) ? RXW : CXW;
  localparam int unsigned CntW  = $clog2(DivW);
  localparam int unsigned KRW   = (MaxKernelRows > 1) ? $clog2(MaxKernelRows) : 1;
  localparam int unsigned Depth = MaxKernelRows * (2 ** CW);
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned HLim  = (MaxHeight < 511) ? MaxHeight : 511;
  localparam int unsigned WLim  = (MaxWidth < 511) ? MaxWidth : 511;
  localparam int unsigned KRLim = (MaxKernelRows < 15) ? MaxKernelRows : 15;
  localparam int unsigned KCLim = (MaxKernelCols < 15) ? MaxKernelCols : 15;

  // configuration registers
  logic [DimW-1:0]        ph_q, pw_q;
  logic [KerW-1:0]        kr_q, kc_q, sr_q, sc_q;
  logic signed [OffW-1:0] ioff_q, ooff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= DimW'(8);
      pw_q   <= DimW'(8);
      kr_q   <= KerW'(2);
      kc_q   <= KerW'(2);
      sr_q   <= KerW'(2);
      sc_q   <= KerW'(2);
      ioff_q <= '0;
      ooff_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PLANE_HEIGHT: ph_q   <= cfg_data_i;
        CFG_PLANE_WIDTH:  pw_q   <= cfg_data_i;
        CFG_KERNEL_ROWS:  kr_q   <= cfg_data_i[KerW-1:0];
        CFG_KERNEL_COLS:  kc_q   <= cfg_data_i[KerW-1:0];
        CFG_STRIDE_ROWS:  sr_q   <= cfg_data_i[KerW-1:0];
        CFG_STRIDE_COLS:  sc_q   <= cfg_data_i[KerW-1:0];
        CFG_IN_OFFSET:    ioff_q <= cfg_data_i;
        CFG_OUT_OFFSET:   ooff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [DimW-1:0] h_eff, w_eff, krl, kcl;
  logic [KerW-1:0] kr_eff, kc_eff, sr_eff, sc_eff;

  always_comb begin
    h_eff  = (ph_q == '0) ? DimW'(1) : ((ph_q > DimW'(HLim)) ? DimW'(HLim) : ph_q);
    w_eff  = (pw_q == '0) ? DimW'(1) : ((pw_q > DimW'(WLim)) ? DimW'(WLim) : pw_q);
    krl    = (h_eff < DimW'(KRLim)) ? h_eff : DimW'(KRLim);
    kcl    = (w_eff < DimW'(KCLim)) ? w_eff : DimW'(KCLim);
    kr_eff = (kr_q == '0) ? KerW'(1) : ((DimW'(kr_q) > krl) ? krl[KerW-1:0] : kr_q);
    kc_eff = (kc_q == '0) ? KerW'(1) : ((DimW'(kc_q) > kcl) ? kcl[KerW-1:0] : kc_q);
    sr_eff = (sr_q == '0) ? KerW'(1) : sr_q;
    sc_eff = (sc_q == '0) ? KerW'(1) : sc_q;
  end

  // plane position
  logic [RW-1:0]   row_q;
  logic [CW-1:0]   col_q;
  logic [RXW-1:0]  row_x, h_x;
  logic [CXW-1:0]  col_x, w_x;
  logic            stale;
  logic [PixW-1:0] pix_q;
  logic            last_q;

  assign row_x = RXW'(row_q);
  assign col_x = CXW'(col_q);
  assign h_x   = RXW'(h_eff);
  assign w_x   = CXW'(w_eff);
  assign stale = (row_x >= h_x) || (col_x >= w_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.accept) begin
      if (stale) begin
        row_q <= '0;
        col_q <= '0;
      end
    end else if (cmd_i.advance) begin
      if (last_q) begin
        row_q <= '0;
        col_q <= '0;
      end else if (col_x + CXW'(1) >= w_x) begin
        col_q <= '0;
        row_q <= (row_x + RXW'(1) >= h_x) ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q  <= pixel_i;
      last_q <= last_i;
    end
  end

  // three restoring division lanes: row mod kernel rows, window row, window column
  logic [DivW-1:0] na_q, nb_q, nc_q;
  logic [KerW-1:0] ra_q, rb_q, rc_q;
  logic [CntW-1:0] cnt_q;
  logic [RXW-1:0]  row_s, row_first;
  logic [CXW-1:0]  col_s, col_first;

  assign row_s     = stale ? '0 : row_x;
  assign col_s     = stale ? '0 : col_x;
  assign row_first = row_s + RXW'(1) - RXW'(kr_eff);
  assign col_first = col_s + CXW'(1) - CXW'(kc_eff);

  function automatic logic [KerW+DivW-1:0] div_step(input logic [KerW-1:0] rem,
                                                   input logic [DivW-1:0] num,
                                                   input logic [KerW-1:0] den);
    logic [KerW:0] t;
    logic          ge;
    t  = {rem, num[DivW-1]};
    ge = t >= {1'b0, den};
    return {ge ? KerW'(t - {1'b0, den}) : t[KerW-1:0], num[DivW-2:0], ge};
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      na_q  <= DivW'(row_s);
      nb_q  <= DivW'(row_first);
      nc_q  <= DivW'(col_first);
      ra_q  <= '0;
      rb_q  <= '0;
      rc_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      {ra_q, na_q} <= div_step(ra_q, na_q, kr_eff);
      {rb_q, nb_q} <= div_step(rb_q, nb_q, sr_eff);
      {rc_q, nc_q} <= div_step(rc_q, nc_q, sc_eff);
      cnt_q        <= cnt_q + CntW'(1);
    end
  end

  assign status_o.div_last = cnt_q == CntW'(DivW - 1);
  assign status_o.hit = (row_x + RXW'(1) >= RXW'(kr_eff)) &&
                        (col_x + CXW'(1) >= CXW'(kc_eff)) &&
                        (rb_q == '0) && (rc_q == '0);

  // window walk over the kernel rows and kernel columns of the window in the line store
  logic [KRW-1:0]  s_q;
  logic [KerW-1:0] j_q;
  logic [CW-1:0]   cst_q;
  logic            s_last, j_last;
  logic            rd_valid_q;
  logic [AW-1:0]   addr;
  logic [PixW-1:0] rdata;

  assign s_last = KerW'(s_q) == kr_eff - KerW'(1);
  assign j_last = j_q == kc_eff - KerW'(1);
  assign status_o.walk_last = s_last && j_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_px) begin
      s_q   <= '0;
      j_q   <= '0;
      cst_q <= col_q + CW'(1) - CW'(kc_eff);
    end else if (cmd_i.walk) begin
      if (j_last) begin
        j_q <= '0;
        s_q <= s_q + KRW'(1);
      end else begin
        j_q <= j_q + KerW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.walk;
    end
  end

  assign addr = cmd_i.write_px ? AW'({ra_q[KRW-1:0], col_q})
                               : AW'({s_q, cst_q + CW'(j_q)});

  mp2d_ram #(
    .Width(PixW),
    .Depth(Depth)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write_px),
    .addr_i (addr),
    .wdata_i(pix_q),
    .rdata_o(rdata)
  );

  // running maximum
  logic signed [AccW-1:0] best_q, cand;

  assign cand = AccW'($signed(rdata)) + AccW'(ioff_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_px) begin
      best_q <= PoolFloor;
    end else if (rd_valid_q && (cand > best_q)) begin
      best_q <= cand;
    end
  end

  // output register
  logic             out_valid_q;
  logic [OutW-1:0]  out_data_q;
  logic [AccW-1:0]  res;

  assign res = best_q + AccW'(ooff_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= {nc_q[7:0], nb_q[7:0], res[7:0]};
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hdl/max_pool_2d_int8.sv
// Top level of the int8 2-D max pooling block: controller plus datapath.
// Depends on mp2d_pkg, mp2d_ctrl, mp2d_datapath and mp2d_ram.
//
// Pixels of one plane after another arrive in row-major order; each window
// whose bottom-right corner is the current pixel gives one result. Every pixel
// goes through an accept, restoring division steps on DivW-bit lanes (DivW =
// max(10, clog2(MAX_HEIGHT)+1, clog2(MAX_WIDTH)+1), 10 at the defaults) and one
// line store write; a corner pixel adds one read of the single line store port
// per window sample, then a drain and a load. No new pixel is taken before the
// last one is through. The output register holds a result while the next pixel
// is taken; a new result waits only if it is still full.
module max_pool_2d_int8 #(
  parameter int unsigned MAX_WIDTH       = mp2d_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT      = mp2d_pkg::MaxHeightDef,
  parameter int unsigned MAX_KERNEL_ROWS = mp2d_pkg::MaxKernelRowsDef,
  parameter int unsigned MAX_KERNEL_COLS = mp2d_pkg::MaxKernelColsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mp2d_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [mp2d_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // pixel
  input  logic                      s_axis_tlast,   // last_pixel
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata    // pooled, out_row, out_col
);
  import mp2d_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mp2d_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  mp2d_datapath #(
    .MaxWidth     (MAX_WIDTH),
    .MaxHeight    (MAX_HEIGHT),
    .MaxKernelRows(MAX_KERNEL_ROWS),
    .MaxKernelCols(MAX_KERNEL_COLS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pixel_i    (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status)
  );

`ifndef ASSERT_OFF
  // one pixel at a time: no transfer straight after another
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous pixel in flight");

  // a loaded result is always presented
  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> m_axis_tvalid)
    else $error("loaded result not presented");

  // never overwrite a result still waiting
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before transfer");
`endif

endmodule

FILE: test/tb.sv
// Self-checking bench for max_pool_2d_int8: streams int8 planes through the
// stream ports, predicts every pooled window and checks each output transfer.
// Depends on mp2d_pkg and the max_pool_2d_int8 RTL only.
`timescale 1ns / 1ps

module tb;
  import mp2d_pkg::*;

  // pooled in the lowest byte, then out_row, then out_col
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] pooled;
  } window_max_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic [IdxW-1:0] cfg_idx_i     = '0;
  logic [CfgW-1:0] cfg_data_i    = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata  = '0;  // pixel
  logic            s_axis_tlast  = 1'b0; // last_pixel
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [23:0]     m_axis_tdata;         // pooled, out_row, out_col

  max_pool_2d_int8 DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers and of the line store
  logic [8:0]        plane_h, plane_w;
  logic [3:0]        ker_r, ker_c, step_r, step_c;
  logic signed [8:0] in_off, out_off;
  logic [7:0]        line_store [2048];
  int unsigned       cur_row, cur_col;

  window_max_t pending_max[$];
  int send_idle_pct, recv_stall_pct, hold_left;
  int mismatches, pixels_sent, windows_seen;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // one pixel through the pooling window logic; returns 1 when a window closes
  function automatic bit pool_pixel(input logic [7:0] px, input bit last,
                                    output window_max_t res);
    int unsigned h, w, kr, kc, sr, sc, r, c, i, j;
    int best, v;
    h  = clamp(plane_h, 1, 256);
    w  = clamp(plane_w, 1, 256);
    kr = clamp(ker_r, 1, (h < 8) ? h : 8);
    kc = clamp(ker_c, 1, (w < 8) ? w : 8);
    sr = (step_r == 0) ? 1 : step_r;
    sc = (step_c == 0) ? 1 : step_c;
    res = '0;
    pool_pixel = 1'b0;
    // restart a position left outside a shrunken plane
    if (cur_row >= h || cur_col >= w) begin
      cur_row = 0;
      cur_col = 0;
    end
    r = cur_row;
    c = cur_col;
    line_store[(r % kr) * 256 + c] = px;
    if (r + 1 >= kr && c + 1 >= kc && (r + 1 - kr) % sr == 0 && (c + 1 - kc) % sc == 0) begin
      best = -128;
      for (i = r + 1 - kr; i <= r; i++)
        for (j = c + 1 - kc; j <= c; j++) begin
          v = $signed(line_store[(i % kr) * 256 + j]) + in_off;
          if (v > best) best = v;
        end
      res.pooled = 8'(best + out_off);
      res.row    = 8'((r + 1 - kr) / sr);
      res.col    = 8'((c + 1 - kc) / sc);
      pool_pixel = 1'b1;
    end
    if (last) begin
      cur_row = 0;
      cur_col = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      cur_row = r;
      cur_col = c;
    end
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [8:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_PLANE_HEIGHT: plane_h = val;
      CFG_PLANE_WIDTH:  plane_w = val;
      CFG_KERNEL_ROWS:  ker_r   = val[3:0];
      CFG_KERNEL_COLS:  ker_c   = val[3:0];
      CFG_STRIDE_ROWS:  step_r  = val[3:0];
      CFG_STRIDE_COLS:  step_c  = val[3:0];
      CFG_IN_OFFSET:    in_off  = val;
      CFG_OUT_OFFSET:   out_off = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int h, w, kr, kc, sr, sc, io, oo);
    write_reg(CFG_PLANE_HEIGHT, 9'(h));
    write_reg(CFG_PLANE_WIDTH,  9'(w));
    write_reg(CFG_KERNEL_ROWS,  9'(kr));
    write_reg(CFG_KERNEL_COLS,  9'(kc));
    write_reg(CFG_STRIDE_ROWS,  9'(sr));
    write_reg(CFG_STRIDE_COLS,  9'(sc));
    write_reg(CFG_IN_OFFSET,    9'(io));
    write_reg(CFG_OUT_OFFSET,   9'(oo));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(input logic [7:0] px, input bit last);
    window_max_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (pool_pixel(px, last, res)) pending_max.push_back(res);
    pixels_sent++;
  endtask

  // hold the input until every window is out and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic send_planes(input int planes, input bit may_cut);
    int n;
    for (int p = 0; p < planes; p++) begin
      n = clamp(plane_h, 1, 256) * clamp(plane_w, 1, 256);
      if (may_cut && $urandom_range(5) == 0) n = $urandom_range(1, n);
      for (int k = 0; k < n; k++)
        send_pixel(8'($urandom), (p == planes - 1 && k == n - 1) || (k == n - 1 && n < 300));
    end
  endtask

  function automatic void note_mismatch(input string what, input window_max_t exp_v,
                                        input window_max_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected pooled %0d row %0d col %0d, got pooled %0d row %0d col %0d",
               $realtime, what, $signed(exp_v.pooled), exp_v.row, exp_v.col,
               $signed(got.pooled), got.row, got.col);
  endfunction

  always @(posedge clk_i) begin
    window_max_t got, exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      windows_seen++;
      if (pending_max.size() == 0) begin
        note_mismatch("unexpected transfer", '0, got);
      end else begin
        exp_v = pending_max.pop_front();
        if (got.pooled !== exp_v.pooled || got.row !== exp_v.row || got.col !== exp_v.col)
          note_mismatch("window mismatch", exp_v, got);
      end
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_small_windows();
    logic [7:0] px [12] = '{8'h7f, 8'h80, 8'h00, 8'hff, 8'h80, 8'h80, 8'h01,
                             8'h7f, 8'h55, 8'haa, 8'h80, 8'h7e};
    set_config(3, 4, 2, 2, 1, 1, 0, 0);
    for (int k = 0; k < 12; k++) send_pixel(px[k], k == 11);
    wait_idle();
  endtask

  task automatic test_offsets();
    set_config(1, 1, 1, 1, 1, 1, -256, 255);
    send_pixel(8'h7f, 1'b0);
    send_pixel(8'h80, 1'b1);
    wait_idle();
    set_config(1, 1, 1, 1, 1, 1, 255, -256);
    send_pixel(8'h7f, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_clamping();
    // zero plane size, oversized kernel, zero stride
    set_config(0, 0, 15, 15, 0, 0, 3, -3);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h7f, 1'b1);
    wait_idle();
    // oversized plane, kernel wider than the plane
    set_config(511, 3, 3, 15, 0, 0, 0, 0);
    for (int k = 0; k < 9; k++) send_pixel(8'($urandom), k == 8);
    wait_idle();
  endtask

  task automatic test_stale_position();
    set_config(8, 8, 2, 2, 2, 2, 0, 0);
    for (int k = 0; k < 5; k++) send_pixel(8'($urandom), 1'b0);
    wait_idle();
    write_reg(CFG_PLANE_WIDTH, 9'd4);
    cfg_we_i <= 1'b0;
    for (int k = 0; k < 8; k++) send_pixel(8'($urandom), k == 7);
    wait_idle();
  endtask

  task automatic test_largest();
    set_config(256, 8, 8, 8, 8, 8, $urandom_range(511), $urandom_range(511));
    for (int k = 0; k < 64; k++) send_pixel(8'($urandom), k == 63);
    wait_idle();
    set_config(1, 256, 1, 8, 1, 8, 0, 0);
    for (int k = 0; k < 24; k++) send_pixel(8'($urandom), k == 23);
    wait_idle();
  endtask

  task automatic test_hold_off();
    set_config(4, 8, 1, 1, 1, 1, $urandom_range(511), $urandom_range(511));
    hold_left = 400;
    for (int k = 0; k < 32; k++) send_pixel(8'($urandom), k == 31);
    wait_idle();
  endtask

  task automatic test_random(input int idle_pct, stall_pct, quota);
    int h, w, stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = pixels_sent + quota;
    while (pixels_sent < stop_at) begin
      h = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
      w = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
      set_config(h, w,
                 ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(1, (h < 8) ? h : 8),
                 ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(1, (w < 8) ? w : 8),
                 $urandom_range(8), $urandom_range(8), $urandom_range(511), $urandom_range(511));
      send_planes($urandom_range(1, 3), 1'b1);
      wait_idle();
    end
  endtask

  initial begin
    plane_h = 8; plane_w = 8; ker_r = 2; ker_c = 2; step_r = 2; step_c = 2;
    in_off = '0; out_off = '0;
    foreach (line_store[i]) line_store[i] = '0;
    cur_row = 0; cur_col = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);
    test_small_windows();
    test_offsets();
    test_clamping();
    test_stale_position();
    test_largest();
    test_hold_off();
    test_random(0, 0, 100);
    test_random(54, 0, 100);
    test_random(0, 54, 100);
    test_random(8, 8, 100);
    wait_idle();
    $display("Sent %0d pixels over directed and random plane shapes, received %0d windows.",
             pixels_sent, windows_seen);
    $display("Covered offsets, clamped sizes, stale positions, output hold-off and idling.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule
